FILE: src/rau_pkg.sv
package rau_pkg;

    localparam int OPW   = 16;        // operand width
    localparam int NW    = 2 * OPW;   // product and gcd datapath width
    localparam int UW    = NW + 1;    // shared add/sub unit width, signed result width
    localparam int DENW  = NW - 1;    // result denominator width
    localparam int KW    = $clog2(NW);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;

    typedef struct packed {
        logic [2:0]            operation;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [UW-1:0] result_num;
        logic [DENW-1:0]      result_den;
        logic                 equal;
        logic                 error;
    } t_rsp;

    // magnitude of a two's complement operand, most negative value included
    function automatic logic [OPW-1:0] mag(input logic [OPW-1:0] v);
        mag = v[OPW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

FILE: src/rau_addsub.sv
module rau_addsub (
    input  logic [rau_pkg::UW-1:0] i_a,
    input  logic [rau_pkg::UW-1:0] i_b,
    input  logic                   i_sub,
    output logic [rau_pkg::UW-1:0] o_res,
    output logic                   o_borrow
);
    import rau_pkg::*;

    logic [UW:0] sum;

    always_comb begin
        sum = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{UW{1'b0}}, i_sub};
    end

    assign o_res    = sum[UW-1:0];
    // borrow only means something when subtracting
    assign o_borrow = i_sub & ~sum[UW];

endmodule

FILE: src/rau_mul.sv
module rau_mul (
    input  logic [rau_pkg::OPW-1:0] i_x,
    input  logic [rau_pkg::OPW-1:0] i_y,
    output logic [rau_pkg::NW-1:0]  o_p
);
    import rau_pkg::*;

    always_comb begin
        o_p = NW'(i_x) * NW'(i_y);
    end

endmodule

FILE: src/rational_arithmetic_unit.sv
// channel   signals                                  direction
// request   i_req_valid / o_req_ready / i_req        in  (op, a_num, a_den, b_num, b_den)
// response  o_rsp_valid / i_rsp_ready / o_rsp        out (result_num, result_den, equal, error)
//
// one request at a time; o_req_ready is high only while the sequencer is idle
// error cases and unknown operations go from accept straight to S_FIN, which registers the response
// general case: multiplies in S_MUL0 and S_MUL1 (and S_MUL2 for add, sub, equal), combine
// (add, sub, equal), zero check, binary gcd on the shared add/sub unit (shift or subtract
// steps plus swaps), normalize, then two restoring divides when the odd gcd part is not 1
// synchronous active-low reset clears the sequencer and response valid only
// a stalled response holds in the output register; the next request is taken meanwhile
module rational_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rau_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output rau_pkg::t_rsp o_rsp
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_ZCHK, S_GCD, S_SHIFT, S_DIV, S_FIN
    } t_state;

    t_state          r_state;
    logic [2:0]      r_op;
    logic [OPW-1:0]  r_an, r_ad, r_bn, r_bd;
    logic            r_sa, r_sb, r_sbe, r_swp, r_neg, r_eq, r_err, r_phase;
    logic [NW-1:0]   r_n, r_d, r_u, r_v, r_g, r_q;
    logic [NW-1:0]   r_r;
    logic [KW-1:0]   r_k, r_cnt;

    logic [OPW-1:0]  an, ad, bn, bd;
    logic            sa, sb, quick, quick_err;
    logic [OPW-1:0]  mul_x, mul_y;
    logic [NW-1:0]   prod;
    logic [UW-1:0]   alu_a, alu_b, alu_res;
    logic            alu_sub, alu_borrow;
    logic [UW-1:0]   div_t;
    logic [NW-1:0]   q_next;
    logic            out_free;

    // request decode
    always_comb begin
        an = mag(i_req.a_num);
        ad = mag(i_req.a_den);
        bn = mag(i_req.b_num);
        bd = mag(i_req.b_den);
        sa = i_req.a_num[OPW-1] ^ i_req.a_den[OPW-1];
        sb = i_req.b_num[OPW-1] ^ i_req.b_den[OPW-1];
        quick     = 1'b0;
        quick_err = 1'b0;
        if (i_req.operation > OP_EQ) begin
            quick = 1'b1;
        end else if (ad == '0 || bd == '0) begin
            quick     = 1'b1;
            quick_err = 1'b1;
        end else if (i_req.operation == OP_DIV && bn == '0) begin
            quick     = 1'b1;
            quick_err = 1'b1;
        end
    end

    // multiplier operand select
    always_comb begin
        mul_x = r_an;
        mul_y = r_bd;
        case (r_state)
            S_MUL0: begin
                mul_x = r_an;
                mul_y = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                mul_x = r_ad;
                mul_y = (r_op == OP_DIV) ? r_bn : r_bd;
            end
            S_MUL2: begin
                mul_x = r_bn;
                mul_y = r_ad;
            end
            default: begin
                mul_x = r_an;
                mul_y = r_bd;
            end
        endcase
    end

    rau_mul u_mul (
        .i_x (mul_x),
        .i_y (mul_y),
        .o_p (prod)
    );

    assign div_t = {r_r, r_q[NW-1]};

    // shared add/sub unit operand select
    always_comb begin
        alu_a   = {1'b0, r_n};
        alu_b   = {1'b0, r_v};
        alu_sub = 1'b1;
        case (r_state)
            S_COMB: begin
                alu_a   = {1'b0, r_n};
                alu_b   = {1'b0, r_v};
                alu_sub = (r_op == OP_EQ) || (r_sa != r_sbe);
            end
            S_GCD: begin
                alu_a   = {1'b0, r_u};
                alu_b   = {1'b0, r_v};
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = div_t;
                alu_b   = {1'b0, r_g};
                alu_sub = 1'b1;
            end
            S_FIN: begin
                alu_a   = '0;
                alu_b   = {1'b0, r_n};
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = {1'b0, r_n};
                alu_b   = {1'b0, r_v};
                alu_sub = 1'b1;
            end
        endcase
    end

    rau_addsub u_addsub (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_sub    (alu_sub),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign q_next      = {r_q[NW-2:0], ~alu_borrow};
    assign out_free    = !o_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_rsp_valid <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                o_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op  <= i_req.operation;
                        r_an  <= an;
                        r_ad  <= ad;
                        r_bn  <= bn;
                        r_bd  <= bd;
                        r_sa  <= sa;
                        r_sb  <= sb;
                        r_sbe <= (i_req.operation == OP_SUB) ? ~sb : sb;
                        r_neg <= quick ? 1'b0 : (sa ^ sb);
                        r_eq  <= 1'b0;
                        r_err <= quick_err;
                        r_n   <= '0;
                        r_d   <= NW'(1);
                        r_state <= quick ? S_FIN : S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_n     <= prod;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_d <= prod;
                    if (r_op == OP_MUL || r_op == OP_DIV) begin
                        r_state <= S_ZCHK;
                    end else begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_v     <= prod;
                    r_swp   <= 1'b0;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_op == OP_EQ) begin
                        r_eq    <= (r_n == '0 && r_v == '0) ||
                                   (alu_res == '0 && r_sa == r_sb);
                        r_n     <= '0;
                        r_d     <= NW'(1);
                        r_neg   <= 1'b0;
                        r_state <= S_FIN;
                    end else if (!alu_sub) begin
                        r_n     <= alu_res[NW-1:0];
                        r_neg   <= r_sa;
                        r_state <= S_ZCHK;
                    end else if (alu_borrow) begin
                        // larger term second: swap and subtract again
                        r_n   <= r_v;
                        r_v   <= r_n;
                        r_swp <= ~r_swp;
                    end else begin
                        r_n     <= alu_res[NW-1:0];
                        r_neg   <= r_swp ? r_sbe : r_sa;
                        r_state <= S_ZCHK;
                    end
                end
                S_ZCHK: begin
                    if (r_n == '0) begin
                        r_d     <= NW'(1);
                        r_neg   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_u     <= r_n;
                        r_v     <= r_d;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_u == '0) begin
                        r_g     <= r_v;
                        r_state <= S_SHIFT;
                    end else if (r_v == '0) begin
                        r_g     <= r_u;
                        r_state <= S_SHIFT;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (alu_borrow) begin
                        r_u <= r_v;
                        r_v <= r_u;
                    end else begin
                        r_u <= alu_res[NW:1];
                    end
                end
                S_SHIFT: begin
                    // remove common power of two, odd part goes through the divider
                    r_n     <= r_n >> r_k;
                    r_d     <= r_d >> r_k;
                    r_q     <= r_n >> r_k;
                    r_r     <= '0;
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                    r_state <= (r_g == NW'(1)) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    r_r   <= alu_borrow ? div_t[NW-1:0] : alu_res[NW-1:0];
                    r_q   <= q_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == KW'(NW - 1)) begin
                        r_r   <= '0;
                        r_cnt <= '0;
                        if (!r_phase) begin
                            r_n     <= q_next;
                            r_q     <= r_d;
                            r_phase <= 1'b1;
                        end else begin
                            r_d     <= q_next;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_rsp.result_num <= r_neg ? alu_res : {1'b0, r_n};
                        o_rsp.result_den <= r_d[DENW-1:0];
                        o_rsp.equal      <= r_eq;
                        o_rsp.error      <= r_err;
                        o_rsp_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_eq_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.error && o_rsp.equal))
        else $error("equal and error both set");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.result_den != '0)
        else $error("zero result denominator");

    a_zero_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.result_num == '0) |-> o_rsp.result_den == DENW'(1))
        else $error("zero numerator not reduced to 0/1");

    a_gcd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GCD |-> (r_u != '0 || r_v != '0))
        else $error("gcd operands both zero");

    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_g[0])
        else $error("divisor not odd");

endmodule

FILE: verif/rational_arithmetic_unit_tb.sv
module rational_arithmetic_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam logic [2:0] OP_MAX_CODE = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    t_rsp pending_results[$];
    int   err_cnt = 0;
    bit   idling_on = 1'b1;

    rational_arithmetic_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] magnitude(input logic [OPW-1:0] v);
        logic [OPW:0] m;
        m = v[OPW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        return 64'(m);
    endfunction

    // reduced fraction, equality flag and error flag for one request
    function automatic t_rsp rational_result(input t_req r);
        logic [63:0] an, ad, bn, bd, pa, pb, num, den, x, y, t, snum;
        logic        sa, sb, sbe, neg;
        t_rsp        rsp;
        rsp.result_num = '0;
        rsp.result_den = DENW'(1);
        rsp.equal      = 1'b0;
        rsp.error      = 1'b0;
        if (r.operation > OP_EQ) return rsp;
        an = magnitude(r.a_num);
        ad = magnitude(r.a_den);
        bn = magnitude(r.b_num);
        bd = magnitude(r.b_den);
        sa = r.a_num[OPW-1] ^ r.a_den[OPW-1];
        sb = r.b_num[OPW-1] ^ r.b_den[OPW-1];
        if (ad == 0 || bd == 0) begin
            rsp.error = 1'b1;
            return rsp;
        end
        neg = 1'b0;
        num = 0;
        den = 1;
        case (r.operation)
            OP_EQ: begin
                pa = an * bd;
                pb = bn * ad;
                rsp.equal = (pa == 0 && pb == 0) || (pa == pb && sa == sb);
                return rsp;
            end
            OP_ADD, OP_SUB: begin
                pa  = an * bd;
                pb  = bn * ad;
                sbe = (r.operation == OP_SUB) ? ~sb : sb;
                if (sa == sbe) begin
                    num = pa + pb;
                    neg = sa;
                end else if (pa >= pb) begin
                    num = pa - pb;
                    neg = sa;
                end else begin
                    num = pb - pa;
                    neg = sbe;
                end
                den = ad * bd;
            end
            OP_MUL: begin
                num = an * bn;
                den = ad * bd;
                neg = sa ^ sb;
            end
            default: begin
                if (bn == 0) begin
                    rsp.error = 1'b1;
                    return rsp;
                end
                num = an * bd;
                den = ad * bn;
                neg = sa ^ sb;
            end
        endcase
        if (num == 0) return rsp;
        x = num;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        num  = num / x;
        den  = den / x;
        snum = neg ? (64'd0 - num) : num;
        rsp.result_num = snum[UW-1:0];
        rsp.result_den = den[DENW-1:0];
        return rsp;
    endfunction

    function automatic t_req make_req(input logic [2:0] op, input int an, input int ad,
                                      input int bn, input int bd);
        t_req r;
        r.operation = op;
        r.a_num     = an[OPW-1:0];
        r.a_den     = ad[OPW-1:0];
        r.b_num     = bn[OPW-1:0];
        r.b_den     = bd[OPW-1:0];
        return r;
    endfunction

    function automatic int random_operand();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $signed(16'($urandom));
            4, 5, 6, 7: v = $urandom_range(0, 40) - 20;
            default: begin
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -32767;
                    3: v = -1;
                    4: v = 1;
                    default: v = 0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic t_req random_request();
        logic [2:0] op;
        if ($urandom_range(0, 19) == 0)
            op = 3'($urandom_range(OP_EQ + 1, OP_MAX_CODE));
        else
            op = 3'($urandom_range(OP_ADD, OP_EQ));
        return make_req(op, random_operand(), random_operand(), random_operand(),
                        random_operand());
    endfunction

    // response side back-pressure in short bursts
    initial begin
        int stall_left;
        stall_left = 0;
        i_rsp_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // check responses first so a stray one cannot pair with a same-edge request
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n === 1'b1) begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (pending_results.size() == 0) begin
                    $error("response with no request outstanding: num %0d den %0d",
                           o_rsp.result_num, o_rsp.result_den);
                    err_cnt++;
                end else begin
                    exp_rsp = pending_results.pop_front();
                    if (o_rsp.result_num !== exp_rsp.result_num) begin
                        $error("result_num: expected %0d, actual %0d",
                               exp_rsp.result_num, o_rsp.result_num);
                        err_cnt++;
                    end
                    if (o_rsp.result_den !== exp_rsp.result_den) begin
                        $error("result_den: expected %0d, actual %0d",
                               exp_rsp.result_den, o_rsp.result_den);
                        err_cnt++;
                    end
                    if (o_rsp.equal !== exp_rsp.equal) begin
                        $error("equal: expected %0d, actual %0d", exp_rsp.equal, o_rsp.equal);
                        err_cnt++;
                    end
                    if (o_rsp.error !== exp_rsp.error) begin
                        $error("error: expected %0d, actual %0d", exp_rsp.error, o_rsp.error);
                        err_cnt++;
                    end
                end
            end
            if (i_req_valid && o_req_ready)
                pending_results.push_back(rational_result(i_req));
        end
    end

    // valid is left high after acceptance; the next call keeps or drops it
    task automatic send_request(input t_req r);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    // drop valid and wait for the clock first so the last accepted request is already queued
    task automatic wait_all_results();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        send_request(make_req(OP_ADD, 1, 2, 1, 3));
        // zero numerator after subtraction
        send_request(make_req(OP_SUB, 1, 2, 1, 2));
        send_request(make_req(OP_MUL, 32767, -32768, -32768, 32767));
        send_request(make_req(OP_DIV, -32768, 1, -32768, 1));
        // division by zero
        send_request(make_req(OP_DIV, 3, 4, 0, 5));
        // zero denominators, the equality test included
        send_request(make_req(OP_ADD, 1, 0, 2, 3));
        send_request(make_req(OP_EQ, 1, 2, 1, 0));
        send_request(make_req(OP_ADD, 0, 0, 0, 0));
        send_request(make_req(OP_EQ, 2, 4, -1, -2));
        send_request(make_req(OP_EQ, 0, 5, 0, -3));
        send_request(make_req(OP_EQ, 1, 3, -1, 3));
        send_request(make_req(OP_EQ, -32768, -32768, 32767, 32767));
        // unused operation codes
        send_request(make_req(3'(OP_EQ + 1), 5, 7, 3, 2));
        send_request(make_req(OP_MAX_CODE, -1, -1, -1, -1));
        send_request(make_req(OP_ADD, -32768, 32767, -32768, 32765));
        send_request(make_req(OP_SUB, 32767, -32768, -32768, 32767));
        send_request(make_req(OP_MUL, -32768, -32768, -32768, -32768));
        send_request(make_req(OP_DIV, 32767, 1, 1, -32768));
        // both parts negative gives a positive value
        send_request(make_req(OP_ADD, -1, -1, -1, -1));
        send_request(make_req(OP_MUL, -3, -5, 10, 1));
        send_request(make_req(OP_DIV, 0, 7, 3, 4));
        send_request(make_req(OP_SUB, 0, 1, 5, -7));
        wait_all_results();
    endtask

    task automatic test_mixed_random();
        for (int i = 0; i < 900; i++) begin
            if (i % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
            send_request(random_request());
        end
        idling_on = 1'b1;
        wait_all_results();
    endtask

    // b is a scaled copy of a, sometimes nudged, so equal and zero results show up
    task automatic test_scaled_fractions();
        int         an, ad, k, bn;
        logic [2:0] op;
        for (int i = 0; i < 300; i++) begin
            an = $urandom_range(0, 200) - 100;
            ad = $urandom_range(1, 100);
            if ($urandom_range(0, 1)) ad = -ad;
            k = $urandom_range(1, 300);
            if ($urandom_range(0, 1)) k = -k;
            bn = an * k;
            if ($urandom_range(0, 2) == 0) bn = bn + 1;
            case ($urandom_range(0, 3))
                0:       op = OP_SUB;
                1:       op = OP_DIV;
                default: op = OP_EQ;
            endcase
            send_request(make_req(op, an, ad, bn, ad * k));
        end
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        for (int i = 0; i < 650; i++)
            send_request(random_request());
        wait_all_results();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_mixed_random();
        test_scaled_fractions();
        test_back_to_back();

        repeat (200) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
